/* sv/esspan_pkg.sv */
// ----------------------------------------------------------------------------
// esspan_pkg: shared types and constants for the ellipse scanline span core
// Holds the fixed limits, the pipeline depths and the side-band struct that
// travels with every transaction through the pipeline.
// ----------------------------------------------------------------------------
package esspan_pkg;

  // Largest supported window size and radius.
  localparam int unsigned WindowMax = 1024;
  localparam int unsigned RadiusMax = 511;

  // Pipeline geometry: two multiply stages, one square-root step per stage,
  // one quotient bit per divider stage.
  localparam int unsigned SqrtSteps = 18;
  localparam int unsigned DivSteps  = 9;
  localparam int unsigned SbStages  = 2 + SqrtSteps + DivSteps;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegWindowX = 2'd0;
  localparam logic [1:0] RegWindowY = 2'd1;
  localparam logic [1:0] RegWindowW = 2'd2;
  localparam logic [1:0] RegWindowH = 2'd3;

  // Side-band data carried alongside the arithmetic.
  typedef struct packed {
    logic               vld;
    logic               keep;
    logic signed [11:0] cx;
    logic [9:0]         row;
    logic [8:0]         ry;
    logic [15:0]        color;
  } sb_t;

endpackage

/* sv/ellipse_scanline_span_core.sv */
// ----------------------------------------------------------------------------
// ellipse_scanline_span_core: at most one filled-ellipse scanline span per transaction
// One transaction is accepted every cycle while the result side keeps up.
// Each transaction passes 30 registers, the first loaded at acceptance:
// two multiply stages, the 18-stage square-root pipeline, the 9-stage divider
// and the output register. The whole pipeline advances together and stalls
// on out_ready. Synchronous active-low reset clears all valid bits and loads
// the window registers with origin 0,0 and size 240 by 135.
// ----------------------------------------------------------------------------
module ellipse_scanline_span_core (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [10:0] in_center_x,
  input  logic signed [10:0] in_center_y,
  input  logic [8:0]         in_radius_x,
  input  logic [8:0]         in_radius_y,
  input  logic signed [9:0]  in_row_offset,
  input  logic [15:0]        in_fill_color,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_span_row,
  output logic [9:0]         out_span_first,
  output logic [9:0]         out_span_last,
  output logic [15:0]        out_span_color,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SQ = esspan_pkg::SqrtSteps;
  localparam int unsigned DV = esspan_pkg::DivSteps;
  localparam int unsigned SB = esspan_pkg::SbStages;

  // Configuration registers.
  logic signed [10:0] win_x_r, win_y_r;
  logic [10:0]        win_w_r, win_h_r;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_r <= '0;
      win_y_r <= '0;
      win_w_r <= 11'd240;
      win_h_r <= 11'd135;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        esspan_pkg::RegWindowX: win_x_r <= pwdata[10:0];
        esspan_pkg::RegWindowY: win_y_r <= pwdata[10:0];
        esspan_pkg::RegWindowW: win_w_r <= pwdata[10:0];
        esspan_pkg::RegWindowH: win_h_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      esspan_pkg::RegWindowX: prdata = {{21{win_x_r[10]}}, win_x_r};
      esspan_pkg::RegWindowY: prdata = {{21{win_y_r[10]}}, win_y_r};
      esspan_pkg::RegWindowW: prdata = {21'd0, win_w_r};
      esspan_pkg::RegWindowH: prdata = {21'd0, win_h_r};
      default:                prdata = '0;
    endcase
  end

  // Global pipeline advance: everything moves when the output slot is free.
  logic out_valid_r;
  logic adv;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Saturated window size.
  logic [10:0] win_w_sat, win_h_sat;
  assign win_w_sat = (win_w_r > 11'(esspan_pkg::WindowMax)) ?
                     11'(esspan_pkg::WindowMax) : win_w_r;
  assign win_h_sat = (win_h_r > 11'(esspan_pkg::WindowMax)) ?
                     11'(esspan_pkg::WindowMax) : win_h_r;

  // Stage A: window shift, row check, squares.
  logic signed [11:0] a_cx, a_cy;
  logic signed [12:0] a_row;
  logic [8:0]         a_rx, a_ry;
  logic [9:0]         a_ady;
  logic               a_keep;
  logic [17:0]        a_rx2, a_d;
  logic [17:0]        ry2, ady2;

  always_comb begin
    a_cx  = 12'(in_center_x) - 12'(win_x_r);
    a_cy  = 12'(in_center_y) - 12'(win_y_r);
    a_row = 13'(a_cy) + 13'(in_row_offset);
    a_rx  = (in_radius_x > 9'(esspan_pkg::RadiusMax)) ?
            9'(esspan_pkg::RadiusMax) : in_radius_x;
    a_ry  = (in_radius_y > 9'(esspan_pkg::RadiusMax)) ?
            9'(esspan_pkg::RadiusMax) : in_radius_y;
    a_ady = in_row_offset[9] ? 10'(-in_row_offset) : 10'(in_row_offset);
    a_keep = (a_ry != 9'd0) && (a_ady <= 10'(a_ry)) && !a_row[12] &&
             (a_row < 13'(win_h_sat));
    a_rx2 = 18'(a_rx) * 18'(a_rx);
    ry2   = 18'(a_ry) * 18'(a_ry);
    ady2  = 18'(a_ady[8:0]) * 18'(a_ady[8:0]);
    a_d   = ry2 - ady2;
  end

  esspan_pkg::sb_t sb_r [0:SB-1];
  logic [17:0] rx2_r, d_r;
  logic [35:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r[0].vld <= 1'b0;
      sb_r[1].vld <= 1'b0;
    end else if (adv) begin
      sb_r[0].vld <= in_valid;
      sb_r[1].vld <= sb_r[0].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0].keep  <= a_keep;
      sb_r[0].cx    <= a_cx;
      sb_r[0].row   <= a_row[9:0];
      sb_r[0].ry    <= a_ry;
      sb_r[0].color <= in_fill_color;
      rx2_r         <= a_rx2;
      d_r           <= a_d;
      // Stage B: radicand rx^2 * (ry^2 - dy^2).
      {sb_r[1].keep, sb_r[1].cx, sb_r[1].row, sb_r[1].ry, sb_r[1].color} <=
        {sb_r[0].keep, sb_r[0].cx, sb_r[0].row, sb_r[0].ry, sb_r[0].color};
      n_r <= 36'(rx2_r) * 36'(d_r);
    end
  end

  // Square-root pipeline: one result bit per stage, two radicand bits in.
  logic [20:0] sqr_r [0:SQ-1];
  logic [17:0] sqq_r [0:SQ-1];
  logic [35:0] sqn_r [0:SQ-1];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [20:0] r_in, rr, t;
    logic [17:0] q_in;
    logic [35:0] n_in;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
      assign n_in = n_r;
    end else begin : g_next
      assign r_in = sqr_r[k-1];
      assign q_in = sqq_r[k-1];
      assign n_in = sqn_r[k-1];
    end

    assign rr = {r_in[18:0], n_in[35:34]};
    assign t  = {1'b0, q_in, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[2+k].vld <= 1'b0;
      end else if (adv) begin
        sb_r[2+k].vld <= sb_r[1+k].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        {sb_r[2+k].keep, sb_r[2+k].cx, sb_r[2+k].row, sb_r[2+k].ry,
         sb_r[2+k].color} <= {sb_r[1+k].keep, sb_r[1+k].cx, sb_r[1+k].row,
                              sb_r[1+k].ry, sb_r[1+k].color};
        sqn_r[k] <= {n_in[33:0], 2'b00};
        if (rr >= t) begin
          sqr_r[k] <= rr - t;
          sqq_r[k] <= {q_in[16:0], 1'b1};
        end else begin
          sqr_r[k] <= rr;
          sqq_r[k] <= {q_in[16:0], 1'b0};
        end
      end
    end
  end

  // Divider pipeline: root / ry, one quotient bit per stage, MSB first.
  logic [17:0] dr_r [0:DV-1];
  logic [8:0]  dq_r [0:DV-1];

  for (genvar j = 0; j < DV; j++) begin : g_div
    logic [17:0] rem_in, dvs;
    logic [8:0]  q_in;

    if (j == 0) begin : g_first
      assign rem_in = sqq_r[SQ-1];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = dr_r[j-1];
      assign q_in   = dq_r[j-1];
    end

    assign dvs = 18'(sb_r[1+SQ+j].ry) << (DV-1-j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sb_r[2+SQ+j].vld <= 1'b0;
      end else if (adv) begin
        sb_r[2+SQ+j].vld <= sb_r[1+SQ+j].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        {sb_r[2+SQ+j].keep, sb_r[2+SQ+j].cx, sb_r[2+SQ+j].row, sb_r[2+SQ+j].ry,
         sb_r[2+SQ+j].color} <= {sb_r[1+SQ+j].keep, sb_r[1+SQ+j].cx,
                                 sb_r[1+SQ+j].row, sb_r[1+SQ+j].ry,
                                 sb_r[1+SQ+j].color};
        if (rem_in >= dvs) begin
          dr_r[j] <= rem_in - dvs;
          dq_r[j] <= q_in | (9'd1 << (DV-1-j));
        end else begin
          dr_r[j] <= rem_in;
          dq_r[j] <= q_in;
        end
      end
    end
  end

  // Final stage: span ends and clipping to the window width.
  logic signed [12:0] f_first, f_last, f_wm1;
  logic [9:0]         out_row_r, out_first_r, out_last_r;
  logic [15:0]        out_color_r;
  logic               f_ok;

  always_comb begin
    f_first = 13'(sb_r[SB-1].cx) - 13'(dq_r[DV-1]);
    f_last  = 13'(sb_r[SB-1].cx) + 13'(dq_r[DV-1]);
    f_wm1   = 13'(win_w_sat) - 13'sd1;
    if (f_first < 13'sd0) f_first = 13'sd0;
    if (f_last > f_wm1)   f_last  = f_wm1;
    f_ok = sb_r[SB-1].vld && sb_r[SB-1].keep && (f_first <= f_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r   <= sb_r[SB-1].row;
      out_first_r <= f_first[9:0];
      out_last_r  <= f_last[9:0];
      out_color_r <= sb_r[SB-1].color;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_row   = out_row_r;
  assign out_span_first = out_first_r;
  assign out_span_last  = out_last_r;
  assign out_span_color = out_color_r;

  // A held result keeps its valid flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result dropped while stalled");

  // A delivered span is never empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_first_r <= out_last_r)
    else $error("empty span delivered");

  // Input is taken only when the pipeline advances.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid_r || out_ready))
    else $error("input ready out of step with pipeline");

endmodule

/* verif/ellipse_scanline_span_core_test.sv */
// ----------------------------------------------------------------------------
// ellipse_scanline_span_core_test: self-checking bench for the span core
// Drives random and directed ellipse scanline transactions under several
// window settings, predicts each span in integer arithmetic and checks the
// result stream in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module ellipse_scanline_span_core_test;

  typedef struct packed {
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic [8:0]         rx;
    logic [8:0]         ry;
    logic signed [9:0]  dy;
    logic [15:0]        color;
  } scan_req_t;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  first;
    logic [9:0]  last;
    logic [15:0] color;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [10:0] in_center_x = '0;
  logic signed [10:0] in_center_y = '0;
  logic [8:0] in_radius_x = '0;
  logic [8:0] in_radius_y = '0;
  logic signed [9:0] in_row_offset = '0;
  logic [15:0] in_fill_color = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [9:0] out_span_row, out_span_first, out_span_last;
  logic [15:0] out_span_color;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ellipse_scanline_span_core DUT (.*);

  // Clock generation.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the window registers.
  int win_x = 0, win_y = 0, win_w = 240, win_h = 135;

  scan_req_t pending_reqs[$];
  span_t     expected_spans[$];
  int        error_count = 0;
  bit        traffic_on = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Works out the span for one request, if any.
  function automatic bit predict_span(scan_req_t q, output span_t s);
    int cx, cy, rx, ry, dy, ady, w, h, row, first, last, hw;
    longint unsigned n;
    cx = int'(q.cx) - win_x;
    cy = int'(q.cy) - win_y;
    rx = (q.rx > esspan_pkg::RadiusMax) ? esspan_pkg::RadiusMax : q.rx;
    ry = (q.ry > esspan_pkg::RadiusMax) ? esspan_pkg::RadiusMax : q.ry;
    dy = int'(q.dy);
    ady = dy < 0 ? -dy : dy;
    w = (win_w > esspan_pkg::WindowMax) ? esspan_pkg::WindowMax : win_w;
    h = (win_h > esspan_pkg::WindowMax) ? esspan_pkg::WindowMax : win_h;
    s = '0;
    if (ry == 0 || ady > ry) return 1'b0;
    row = cy + dy;
    if (row < 0 || row >= h) return 1'b0;
    n = longint'(rx) * rx * (longint'(ry) * ry - longint'(ady) * ady);
    hw = int'(int_sqrt(n) / ry);
    first = cx - hw;
    last = cx + hw;
    if (first < 0) first = 0;
    if (last > w - 1) last = w - 1;
    if (first > last) return 1'b0;
    s.row = row[9:0];
    s.first = first[9:0];
    s.last = last[9:0];
    s.color = q.color;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Driver: presents queued requests and predicts at acceptance.
  always @(posedge clk) begin
    span_t s;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (predict_span({in_center_x, in_center_y, in_radius_x, in_radius_y,
                          in_row_offset, in_fill_color}, s))
          expected_spans.push_back(s);
        void'(pending_reqs.pop_front());
        in_gap = rand_gap();
      end
      if (!(in_valid && !in_ready)) begin
        if (traffic_on && pending_reqs.size() > 0 && in_gap == 0) begin
          in_valid <= 1'b1;
          {in_center_x, in_center_y, in_radius_x, in_radius_y, in_row_offset,
           in_fill_color} <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // Monitor: checks results and drives random stalls.
  always @(posedge clk) begin
    span_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          report_mismatch("unexpected span, row", int'(out_span_row), -1);
        end else begin
          e = expected_spans.pop_front();
          if (out_span_row !== e.row)
            report_mismatch("row", int'(out_span_row), int'(e.row));
          if (out_span_first !== e.first)
            report_mismatch("first", int'(out_span_first), int'(e.first));
          if (out_span_last !== e.last)
            report_mismatch("last", int'(out_span_last), int'(e.last));
          if (out_span_color !== e.color)
            report_mismatch("color", int'(out_span_color), int'(e.color));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = rand_gap();
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      esspan_pkg::RegWindowX: win_x = int'($signed(value[10:0]));
      esspan_pkg::RegWindowY: win_y = int'($signed(value[10:0]));
      esspan_pkg::RegWindowW: win_w = int'(value[10:0]);
      esspan_pkg::RegWindowH: win_h = int'(value[10:0]);
      default: ;
    endcase
  endtask

  // Waits until every request is taken and the pipeline has drained.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_spans.size() > 0)
      @(posedge clk);
    repeat (esspan_pkg::SbStages + 10) @(posedge clk);
  endtask

  function automatic scan_req_t make_req(int cx, int cy, int rx, int ry, int dy,
                                         int color);
    scan_req_t q;
    q.cx = 11'(cx);
    q.cy = 11'(cy);
    q.rx = 9'(rx);
    q.ry = 9'(ry);
    q.dy = 10'(dy);
    q.color = 16'(color);
    return q;
  endfunction

  // Random request: mostly well-formed scanlines near the window.
  function automatic scan_req_t rand_req();
    scan_req_t q;
    int ry;
    q.cx = 11'($urandom);
    q.cy = 11'($urandom);
    q.rx = 9'($urandom);
    q.ry = 9'($urandom);
    q.dy = 10'($urandom);
    q.color = 16'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      ry = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 511) : $urandom_range(1, 60);
      q.ry = 9'(ry);
      q.rx = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) :
                                           9'($urandom_range(0, 80));
      q.dy = 10'(int'($urandom_range(0, 2 * ry)) - ry);
      q.cx = 11'(win_x + int'($urandom_range(0, 300)) - 30);
      q.cy = 11'(win_y + int'($urandom_range(0, 200)) - 30);
    end
    return q;
  endfunction

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes and every special case at reset window.
    pending_reqs.push_back(make_req(100, 60, 20, 0, 0, 16'h1234));
    pending_reqs.push_back(make_req(100, 60, 20, 10, 11, 16'hFFFF));
    pending_reqs.push_back(make_req(100, 60, 20, 10, -11, 16'h0000));
    pending_reqs.push_back(make_req(100, 60, 20, 10, 10, 16'hAAAA));
    pending_reqs.push_back(make_req(100, 60, 20, 10, -10, 16'h5555));
    pending_reqs.push_back(make_req(100, 60, 0, 10, 3, 16'h0F0F));
    pending_reqs.push_back(make_req(100, 0, 20, 10, -1, 16'h1111));
    pending_reqs.push_back(make_req(100, 134, 20, 10, 1, 16'h2222));
    pending_reqs.push_back(make_req(100, 134, 20, 10, 0, 16'h3333));
    pending_reqs.push_back(make_req(-1024, 60, 511, 511, 0, 16'h4444));
    pending_reqs.push_back(make_req(1023, 60, 511, 511, 0, 16'h6666));
    pending_reqs.push_back(make_req(-50, 60, 20, 10, 0, 16'h7777));
    pending_reqs.push_back(make_req(300, 60, 20, 10, 0, 16'h8888));
    pending_reqs.push_back(make_req(0, -1024, 511, 511, 511, 16'h9999));
    pending_reqs.push_back(make_req(0, 1023, 511, 511, -511, 16'hBBBB));
    pending_reqs.push_back(make_req(120, 60, 511, 511, -512, 16'hCCCC));
    pending_reqs.push_back(make_req(120, 60, 300, 400, 399, 16'hDDDD));
    traffic_on = 1'b1;
    drain();
    run_phase(150);
    // Extreme window: largest size, negative origin.
    cfg_write(esspan_pkg::RegWindowX, -1024);
    cfg_write(esspan_pkg::RegWindowY, -1024);
    cfg_write(esspan_pkg::RegWindowW, 1024);
    cfg_write(esspan_pkg::RegWindowH, 1024);
    run_phase(100);
    // Oversized sizes and a zero width exercise saturation and the empty window.
    cfg_write(esspan_pkg::RegWindowW, 2047);
    cfg_write(esspan_pkg::RegWindowH, 1500);
    cfg_write(esspan_pkg::RegWindowX, 1023);
    cfg_write(esspan_pkg::RegWindowY, 1023);
    run_phase(60);
    cfg_write(esspan_pkg::RegWindowW, 0);
    cfg_write(esspan_pkg::RegWindowX, 0);
    cfg_write(esspan_pkg::RegWindowY, 0);
    run_phase(30);
    // Smallest window.
    cfg_write(esspan_pkg::RegWindowW, 1);
    cfg_write(esspan_pkg::RegWindowH, 1);
    run_phase(60);
    cfg_write(esspan_pkg::RegWindowX, 37);
    cfg_write(esspan_pkg::RegWindowY, -20);
    cfg_write(esspan_pkg::RegWindowW, 240);
    cfg_write(esspan_pkg::RegWindowH, 135);
    run_phase(100);
    if (error_count == 0)
      $display("PASS ellipse_scanline_span_core");
    else
      $display("FAIL ellipse_scanline_span_core");
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAIL ellipse_scanline_span_core");
    $finish;
  end

endmodule

/* filelist.f */
sv/esspan_pkg.sv
sv/ellipse_scanline_span_core.sv
verif/ellipse_scanline_span_core_test.sv
